// ===== hw/rtl/tcc_pkg.sv =====
package tcc_pkg;

    // Cipher constants
    localparam logic [31:0] TEA_DELTA    = 32'h9e37_79b9;
    localparam int          TEA_ROUNDS   = 32;
    localparam logic [31:0] DEC_SUM_INIT = 32'(TEA_DELTA * TEA_ROUNDS);
    localparam int          BLK_BYTES    = 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY0      = 3'd0;
    localparam logic [2:0] CFG_KEY1      = 3'd1;
    localparam logic [2:0] CFG_KEY2      = 3'd2;
    localparam logic [2:0] CFG_KEY3      = 3'd3;
    localparam logic [2:0] CFG_IV        = 3'd4;
    localparam logic [2:0] CFG_DIRECTION = 3'd5;

    // Item passed from the front stage to the cipher engine
    typedef struct packed {
        logic [63:0] blk;
        logic        restart;
    } tcc_item_t;

    // Register set seen by the engine
    typedef struct packed {
        logic [31:0] key0;
        logic [31:0] key1;
        logic [31:0] key2;
        logic [31:0] key3;
        logic [63:0] iv;
        logic        decrypt;
    } tcc_cfg_t;

endpackage

// ===== hw/rtl/tcc_front.sv =====
module tcc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              decrypt,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [63:0]       in_block,
    input  logic [3:0]        valid_bytes,
    input  logic              restart,
    output logic              push_valid,
    input  logic              push_ready,
    output tcc_pkg::tcc_item_t push_item
);
    import tcc_pkg::*;

    logic      front_valid_reg;
    tcc_item_t front_item_reg;
    tcc_item_t front_item_next;
    logic      in_fire;

    // Fill bytes n..7 with the value 8-n for a short block
    function automatic logic [63:0] pad_block(input logic [63:0] blk, input logic [3:0] n);
        logic [63:0] res;
        logic [7:0]  padv;
        res  = blk;
        padv = {4'd0, 4'(BLK_BYTES) - n};
        if (n < 4'(BLK_BYTES))
        begin
            for (int i = 0; i < BLK_BYTES; i++)
            begin
                if (4'(i) >= n)
                begin
                    res[8*i +: 8] = padv;
                end
            end
        end
        return res;
    endfunction

    assign in_fire = in_valid && in_ready;
    assign in_ready = !front_valid_reg || push_ready;

    // Classify the beat: pad only when encrypting
    always_comb
    begin
        front_item_next.blk     = decrypt ? in_block : pad_block(in_block, valid_bytes);
        front_item_next.restart = restart;
    end

    // Hold one beat until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign push_valid = front_valid_reg;
    assign push_item  = front_item_reg;

endmodule

// ===== hw/rtl/tcc_queue.sv =====
module tcc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tcc_pkg::tcc_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tcc_pkg::tcc_item_t pop_item
);
    import tcc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tcc_item_t      slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push_fire;
    logic           pop_fire;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Advance pointers, wrapping at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && !push_fire |=> count_reg == $past(count_reg) - CW'(1))
        else $error("queue count missed a pop");
`endif

endmodule

// ===== hw/rtl/tcc_engine.sv =====
module tcc_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  tcc_pkg::tcc_cfg_t  cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  tcc_pkg::tcc_item_t pop_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        out_block
);
    import tcc_pkg::*;

    localparam logic [4:0] LAST_ROUND = 5'(TEA_ROUNDS - 1);

    logic        busy_reg;
    logic [4:0]  rnd_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] sum_reg;
    logic [63:0] src_reg;
    logic [63:0] chain_reg;
    logic        started_reg;
    logic        out_valid_reg;
    logic [63:0] out_block_reg;

    logic        pop_fire;
    logic        last;
    logic        out_free;
    logic        step;
    logic [63:0] chain_use;
    logic [31:0] sum_e;
    logic [31:0] a_e;
    logic [31:0] b_e;
    logic [31:0] a_d;
    logic [31:0] b_d;
    logic [31:0] sum_d;
    logic [63:0] res;
    logic [31:0] a_next;
    logic [31:0] b_next;
    logic [31:0] sum_next;

    function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] s,
                                        input logic [31:0] ka, input logic [31:0] kb);
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

    assign pop_ready = !busy_reg;
    assign pop_fire  = pop_valid && pop_ready;
    assign last      = rnd_reg == LAST_ROUND;
    assign out_free  = !out_valid_reg || out_ready;
    assign step      = busy_reg && (!last || out_free);
    assign chain_use = (pop_item.restart || !started_reg) ? cfg.iv : chain_reg;

    // One full round per cycle in either direction; the last round stalls while output is full
    always_comb
    begin
        sum_e = sum_reg + TEA_DELTA;
        a_e   = a_reg + mix(b_reg, sum_e, cfg.key0, cfg.key1);
        b_e   = b_reg + mix(a_e, sum_e, cfg.key2, cfg.key3);
        b_d   = b_reg - mix(a_reg, sum_reg, cfg.key2, cfg.key3);
        a_d   = a_reg - mix(b_d, sum_reg, cfg.key0, cfg.key1);
        sum_d = sum_reg - TEA_DELTA;
        if (cfg.decrypt)
        begin
            a_next   = a_d;
            b_next   = b_d;
            sum_next = sum_d;
            res      = {b_d, a_d} ^ chain_reg;
        end
        else
        begin
            a_next   = a_e;
            b_next   = b_e;
            sum_next = sum_e;
            res      = {b_e, a_e};
        end
    end

    // Control: start, count rounds, hand off the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rnd_reg       <= '0;
            chain_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step && last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop_fire)
            begin
                busy_reg    <= 1'b1;
                rnd_reg     <= '0;
                chain_reg   <= chain_use;
                started_reg <= 1'b1;
            end
            else if (step)
            begin
                if (last)
                begin
                    busy_reg  <= 1'b0;
                    rnd_reg   <= '0;
                    chain_reg <= cfg.decrypt ? src_reg : res;
                end
                else
                begin
                    rnd_reg <= rnd_reg + 5'd1;
                end
            end
        end
    end

    // Datapath: load the block (chained with the IV or the last block when encrypting), then iterate
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            src_reg <= pop_item.blk;
            if (cfg.decrypt)
            begin
                a_reg   <= pop_item.blk[31:0];
                b_reg   <= pop_item.blk[63:32];
                sum_reg <= DEC_SUM_INIT;
            end
            else
            begin
                a_reg   <= pop_item.blk[31:0] ^ chain_use[31:0];
                b_reg   <= pop_item.blk[63:32] ^ chain_use[63:32];
                sum_reg <= '0;
            end
        end
        else if (step)
        begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            sum_reg <= sum_next;
            if (last)
            begin
                out_block_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_block = out_block_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |=> busy_reg && rnd_reg == '0)
        else $error("engine did not start on a popped beat");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> rnd_reg == '0)
        else $error("round counter nonzero while idle");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> out_valid_reg && !busy_reg)
        else $error("final round did not post a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && last && out_valid_reg && !out_ready |=> busy_reg && last)
        else $error("engine left final round with output occupied");
`endif

endmodule

// ===== hw/rtl/tea_cbc_cipher_top.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------
// in       | in_valid / in_ready  | in_block[63:0], valid_bytes[3:0], restart
// out      | out_valid / out_ready| out_block[63:0]
// cfg      | cfg_valid / cfg_ready| cfg_index[2:0], cfg_data[63:0]
//
// In the engine each block is loaded, then runs 32 TEA rounds through one
// shared round unit, since every block chains on the last. An in beat goes
// through the front register and queue. Reset clears the configuration,
// chain state, queue pointers and valid flags, but not the data registers.
// The front register and queue keep taking beats while the engine runs, until the
// queue fills; the engine holds its final round while the output register is occupied.
module tea_cbc_cipher_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] in_block,
    input  logic [3:0]  valid_bytes,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_block
);
    import tcc_pkg::*;

    tcc_cfg_t  cfg_reg;
    logic      push_valid;
    logic      push_ready;
    tcc_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    tcc_item_t pop_item;

    assign cfg_ready = 1'b1;

    // Write the addressed register, drop writes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY0:      cfg_reg.key0    <= cfg_data[31:0];
                CFG_KEY1:      cfg_reg.key1    <= cfg_data[31:0];
                CFG_KEY2:      cfg_reg.key2    <= cfg_data[31:0];
                CFG_KEY3:      cfg_reg.key3    <= cfg_data[31:0];
                CFG_IV:        cfg_reg.iv      <= cfg_data;
                CFG_DIRECTION: cfg_reg.decrypt <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    tcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .decrypt    (cfg_reg.decrypt),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_block   (in_block),
        .valid_bytes(valid_bytes),
        .restart    (restart),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    tcc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    tcc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_item (pop_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_block(out_block)
    );

endmodule
